FILE: sv/pae_pkg.sv
// Shared types, constants and character functions of the armor encoder.
// Used by pae_front, pae_queue, pae_back and pgp_armor_encoder; no dependencies.
package pae_pkg;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MESSAGE_KIND  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CRLF_LINE_END = 2'd1;

   // Job queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // CRC-24
   localparam logic [23:0] CRC_INIT = 24'hB704CE;
   localparam logic [23:0] CRC_POLY = 24'h864CFB;

   // Fixed characters
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_PAD  = 8'h3D;
   localparam logic [7:0] CHAR_DASH = 8'h2D;

   // Armor line text
   localparam logic [8*15-1:0] BEGIN_TXT = "-----BEGIN PGP ";
   localparam logic [8*13-1:0] END_TXT   = "-----END PGP ";
   localparam logic [8*17-1:0] KIND_TXT [4] = '{
      "MESSAGE          ",
      "PUBLIC KEY BLOCK ",
      "PRIVATE KEY BLOCK",
      "SIGNATURE        "
   };
   localparam logic [5:0] KIND_LEN [4] = '{6'd7, 6'd16, 6'd17, 6'd9};

   // What a finish emits before the CRC line
   typedef enum logic [1:0] {
      TAIL_NONE,   // data ended on a group and line boundary
      TAIL_LINE,   // line end only
      TAIL_PAD2,   // one character and two pads
      TAIL_PAD1    // one character and one pad
   } tail_type;

   // One classified transaction, ready for the character sequencer
   typedef struct packed {
      logic        is_finish;
      logic        hdr;        // emit the BEGIN header first
      logic        two;        // data transaction yields two characters
      logic        brk0;       // line end after first character
      logic        brk1;       // line end after second character
      logic [5:0]  sext0;
      logic [5:0]  sext1;
      tail_type    tail;
      logic [5:0]  tail_sext;
      logic [23:0] crc;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } enq_type;

   function automatic logic [7:0] radix_char(logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26)      return w + 8'h41;
      else if (v < 6'd52) return w + 8'd71;
      else if (v < 6'd62) return w - 8'd4;
      else if (v == 6'd62) return 8'h2B;
      else                return 8'h2F;
   endfunction

   function automatic logic [23:0] crc24_byte(logic [23:0] crc, logic [7:0] b);
      logic [23:0] c;
      c = crc ^ {b, 16'h0000};
      for (int i = 0; i < 8; i++) begin
         if (c[23]) c = {c[22:0], 1'b0} ^ CRC_POLY;
         else       c = {c[22:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [5:0] armor_last(logic is_end, logic [1:0] kind);
      logic [5:0] plen;
      plen = is_end ? 6'd13 : 6'd15;
      return plen + KIND_LEN[kind] + 6'd4;
   endfunction

   function automatic logic [7:0] armor_char(logic is_end, logic [1:0] kind,
                                             logic [5:0] idx);
      logic [5:0] plen;
      logic [5:0] j;
      logic [4:0] k;
      plen = is_end ? 6'd13 : 6'd15;
      j    = '0;
      k    = '0;
      if (idx < plen) begin
         j = plen - 6'd1 - idx;
         if (is_end) return END_TXT[8*j[3:0] +: 8];
         else        return BEGIN_TXT[8*j[3:0] +: 8];
      end else if (idx < plen + KIND_LEN[kind]) begin
         j = idx - plen;
         k = 5'd16 - j[4:0];
         return KIND_TXT[kind][8*k +: 8];
      end else begin
         return CHAR_DASH;
      end
   endfunction

endpackage

FILE: sv/pae_front.sv
// Front end: accepts input transactions, runs CRC-24 and radix-64 grouping,
// and queues a job for each but a dataless finish. Depends on pae_pkg.
module pae_front #(
   parameter int CHARS_PER_LINE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             req_command,
   input  logic [7:0]       req_data_byte,
   output pae_pkg::enq_type enq
);

   localparam int unsigned LC_W = $clog2(CHARS_PER_LINE);
   localparam logic [LC_W-1:0] LC_LAST = LC_W'(CHARS_PER_LINE - 1);

   localparam logic [1:0] GROUP_FIRST  = 2'd0;
   localparam logic [1:0] GROUP_SECOND = 2'd1;
   localparam logic [1:0] GROUP_THIRD  = 2'd2;

   logic [1:0]      phase_ff, phase_in;
   logic [3:0]      left_ff, left_in;
   logic [23:0]     crc_ff, crc_in;
   logic [LC_W-1:0] lc_ff, lc_in;
   logic            sent_ff, sent_in;

   logic [LC_W-1:0] lc_a, lc_b;
   logic            brk_a, brk_b;

   always_comb begin
      brk_a = (lc_ff == LC_LAST);
      lc_a  = brk_a ? '0 : lc_ff + 1'b1;
      brk_b = (lc_a == LC_LAST);
      lc_b  = brk_b ? '0 : lc_a + 1'b1;

      phase_in = phase_ff;
      left_in  = left_ff;
      crc_in   = crc_ff;
      lc_in    = lc_ff;
      sent_in  = sent_ff;
      enq      = '0;

      if (accept) begin
         if (!req_command) begin
            enq.push    = 1'b1;
            enq.job.hdr = !sent_ff;
            sent_in     = 1'b1;
            crc_in      = pae_pkg::crc24_byte(crc_ff, req_data_byte);
            case (phase_ff)
               GROUP_FIRST: begin
                  enq.job.sext0 = req_data_byte[7:2];
                  enq.job.brk0  = brk_a;
                  lc_in         = lc_a;
                  left_in       = {2'b00, req_data_byte[1:0]};
                  phase_in      = GROUP_SECOND;
               end
               GROUP_SECOND: begin
                  enq.job.sext0 = {left_ff[1:0], req_data_byte[7:4]};
                  enq.job.brk0  = brk_a;
                  lc_in         = lc_a;
                  left_in       = req_data_byte[3:0];
                  phase_in      = GROUP_THIRD;
               end
               default: begin
                  enq.job.sext0 = {left_ff, req_data_byte[7:6]};
                  enq.job.sext1 = req_data_byte[5:0];
                  enq.job.two   = 1'b1;
                  enq.job.brk0  = brk_a;
                  enq.job.brk1  = brk_b;
                  lc_in         = lc_b;
                  left_in       = '0;
                  phase_in      = GROUP_FIRST;
               end
            endcase
         end else if (sent_ff) begin
            // finish with no data yields no job at all
            enq.push          = 1'b1;
            enq.job.is_finish = 1'b1;
            enq.job.crc       = crc_ff;
            case (phase_ff)
               GROUP_FIRST: begin
                  enq.job.tail = (lc_ff != '0) ? pae_pkg::TAIL_LINE : pae_pkg::TAIL_NONE;
               end
               GROUP_SECOND: begin
                  enq.job.tail      = pae_pkg::TAIL_PAD2;
                  enq.job.tail_sext = {left_ff[1:0], 4'b0000};
               end
               default: begin
                  enq.job.tail      = pae_pkg::TAIL_PAD1;
                  enq.job.tail_sext = {left_ff, 2'b00};
               end
            endcase
            phase_in = GROUP_FIRST;
            left_in  = '0;
            crc_in   = pae_pkg::CRC_INIT;
            lc_in    = '0;
            sent_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= GROUP_FIRST;
         left_ff  <= '0;
         crc_ff   <= pae_pkg::CRC_INIT;
         lc_ff    <= '0;
         sent_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         crc_ff   <= crc_in;
         lc_ff    <= lc_in;
         sent_ff  <= sent_in;
      end
   end

endmodule

FILE: sv/pae_queue.sv
// Short job queue between front and back ends, flip-flop storage.
// Depends on pae_pkg for the job type and depth.
module pae_queue (
   input  logic             clock,
   input  logic             reset,
   input  pae_pkg::enq_type enq,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output pae_pkg::job_type head
);

   pae_pkg::job_type                  entries_ff [pae_pkg::QUEUE_DEPTH];
   logic [pae_pkg::QPTR_W-1:0]        wr_ff, wr_in;
   logic [pae_pkg::QPTR_W-1:0]        rd_ff, rd_in;
   logic [pae_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;

   assign full       = (cnt_ff == pae_pkg::QCNT_W'(pae_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = entries_ff[rd_ff];

   always_comb begin
      wr_in  = enq.push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (enq.push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (!enq.push && pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq.push) entries_ff[wr_ff] <= enq.job;
   end

endmodule

FILE: sv/pae_back.sv
// Back end: walks the job at the queue head one character per cycle while
// not stalled and drives the registered result channel. Depends on pae_pkg.
module pae_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  pae_pkg::job_type head,
   input  logic [1:0]       kind,
   input  logic             crlf,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_message_done
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_HEAD  = 8'b0000_0010,
      ST_LEND  = 8'b0000_0100,
      ST_DATA0 = 8'b0000_1000,
      ST_DATA1 = 8'b0001_0000,
      ST_TAIL  = 8'b0010_0000,
      ST_CRC   = 8'b0100_0000,
      ST_FOOT  = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [5:0]  pos_ff, pos_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff;
   logic [7:0]  char_ff;
   logic        last_ff, done_ff;

   state_type   start_state, cur_state, cur_ret;
   logic [1:0]  cur_cnt;
   logic        idle, busy, slot_free, advance, is_cr, msg_done;
   logic [7:0]  ch;

   always_comb begin
      if (head.is_finish) begin
         case (head.tail)
            pae_pkg::TAIL_LINE: start_state = ST_LEND;
            pae_pkg::TAIL_NONE: start_state = ST_CRC;
            default:            start_state = ST_TAIL;
         endcase
      end else begin
         start_state = head.hdr ? ST_HEAD : ST_DATA0;
      end
   end

   // From idle the head job starts in the same cycle, so jobs run back to back
   assign idle      = (state_ff == ST_IDLE);
   assign cur_state = idle ? start_state : state_ff;
   assign cur_ret   = idle ? ST_CRC : ret_ff;
   assign cur_cnt   = idle ? 2'd1 : cnt_ff;
   assign busy      = !idle || head_valid;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign advance   = busy && slot_free;
   assign is_cr     = crlf && (pos_ff == 6'd0);

   always_comb begin
      state_in = cur_state;
      ret_in   = cur_ret;
      cnt_in   = cur_cnt;
      pos_in   = pos_ff + 6'd1;
      ch       = '0;
      msg_done = 1'b0;
      unique case (cur_state)
         ST_HEAD: begin
            ch = pae_pkg::armor_char(1'b0, kind, pos_ff);
            if (pos_ff == pae_pkg::armor_last(1'b0, kind)) begin
               state_in = ST_LEND;
               cnt_in   = 2'd2;
               ret_in   = ST_DATA0;
               pos_in   = '0;
            end
         end
         ST_LEND: begin
            ch = is_cr ? pae_pkg::CHAR_CR : pae_pkg::CHAR_LF;
            if (!is_cr) begin
               pos_in = '0;
               if (cur_cnt == 2'd2) cnt_in = 2'd1;
               else                 state_in = cur_ret;
            end
         end
         ST_DATA0: begin
            ch     = pae_pkg::radix_char(head.sext0);
            pos_in = '0;
            if (head.brk0) begin
               state_in = ST_LEND;
               cnt_in   = 2'd1;
               ret_in   = head.two ? ST_DATA1 : ST_IDLE;
            end else begin
               state_in = head.two ? ST_DATA1 : ST_IDLE;
            end
         end
         ST_DATA1: begin
            ch       = pae_pkg::radix_char(head.sext1);
            pos_in   = '0;
            state_in = ST_IDLE;
            if (head.brk1) begin
               state_in = ST_LEND;
               cnt_in   = 2'd1;
               ret_in   = ST_IDLE;
            end
         end
         ST_TAIL: begin
            ch = (pos_ff == 6'd0) ? pae_pkg::radix_char(head.tail_sext) : pae_pkg::CHAR_PAD;
            if ((pos_ff == 6'd2) ||
                ((pos_ff == 6'd1) && (head.tail == pae_pkg::TAIL_PAD1))) begin
               state_in = ST_LEND;
               cnt_in   = 2'd1;
               ret_in   = ST_CRC;
               pos_in   = '0;
            end
         end
         ST_CRC: begin
            case (pos_ff)
               6'd0:    ch = pae_pkg::CHAR_PAD;
               6'd1:    ch = pae_pkg::radix_char(head.crc[23:18]);
               6'd2:    ch = pae_pkg::radix_char(head.crc[17:12]);
               6'd3:    ch = pae_pkg::radix_char(head.crc[11:6]);
               default: ch = pae_pkg::radix_char(head.crc[5:0]);
            endcase
            if (pos_ff == 6'd4) begin
               state_in = ST_LEND;
               cnt_in   = 2'd1;
               ret_in   = ST_FOOT;
               pos_in   = '0;
            end
         end
         ST_FOOT: begin
            ch = pae_pkg::armor_char(1'b1, kind, pos_ff);
            if (pos_ff == pae_pkg::armor_last(1'b1, kind)) begin
               state_in = ST_IDLE;
               pos_in   = '0;
               msg_done = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            pos_in   = '0;
         end
      endcase
   end

   assign pop = advance && (state_in == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pos_ff       <= '0;
         cnt_ff       <= 2'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
            ret_ff   <= ret_in;
            pos_ff   <= pos_in;
            cnt_ff   <= cnt_in;
         end
         if (slot_free) rsp_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_ff <= ch;
         last_ff <= (state_in == ST_IDLE);
         done_ff <= msg_done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_run_last     = last_ff;
   assign rsp_message_done = done_ff;

endmodule

FILE: sv/pgp_armor_encoder.sv
// Top level of the OpenPGP ASCII armor encoder: configuration registers,
// front end, job queue and character sequencer. Depends on pae_pkg and pae_* modules.
//
// Message bytes arrive one per transaction (req_command 0) and leave as armored
// ASCII text, one character per result transaction. The first byte of a message
// brings the BEGIN header for the kind in message_kind, a line end and an empty
// line; every byte then feeds the CRC-24 and the radix-64 coder, with a line end
// after every CHARS_PER_LINE data characters. A finish (req_command 1) emits the
// padded tail, '=' with the four-character CRC and the END line; rsp_message_done
// marks its last dash, and the encoder is then ready for a new message. A finish
// with no data before it emits nothing. rsp_run_last marks the last character
// caused by each input transaction. Line ends are LF, or CR LF when
// crlf_line_end is set. Rate: the back end emits one character per cycle while
// rsp_stall is low. A data byte yields one or two characters plus one or two for
// a line end, the header 29 to 41 characters, and a finish 31 to 47 characters.
// The front end classifies a transaction as it is accepted, and a four-entry job
// queue lets it run ahead while results are stalled; req_stall is high only
// while that queue is full. Write the configuration registers only while no
// message output is pending.
module pgp_armor_encoder #(
   parameter int CHARS_PER_LINE = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [7:0]                       req_data_byte,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_char,
   output logic                             rsp_run_last,
   output logic                             rsp_message_done,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pae_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [pae_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [1:0]       kind_ff;
   logic             crlf_ff;
   logic             q_full, head_valid, pop, accept;
   pae_pkg::enq_type enq;
   pae_pkg::job_type head;

   // Always take configuration writes; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= '0;
         crlf_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pae_pkg::CSR_MESSAGE_KIND:  kind_ff <= csr_data[1:0];
            pae_pkg::CSR_CRLF_LINE_END: crlf_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Hold input transactions only while the job queue is full
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   pae_front #(
      .CHARS_PER_LINE (CHARS_PER_LINE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .enq           (enq)
   );

   pae_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .enq        (enq),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   pae_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .kind             (kind_ff),
      .crlf             (crlf_ff),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_run_last     (rsp_run_last),
      .rsp_message_done (rsp_message_done)
   );

endmodule
